### design/msp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response deframer package
// Frame phases, result kinds, register indexes and sync byte values.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] SyncDollar = 8'h24;
  localparam logic [ByteW-1:0] SyncEm     = 8'h4D;
  localparam logic [ByteW-1:0] SyncGt     = 8'h3E;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_EM    = 3'd1,
    PH_GT    = 3'd2,
    PH_LEN   = 3'd3,
    PH_CMD   = 3'd4,
    PH_DATA  = 3'd5,
    PH_CHECK = 3'd6
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_SUM_OK  = 2'd1,
    KIND_SUM_BAD = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FILTER_ENABLE  = 1'd0,
    REG_FILTER_COMMAND = 1'd1
  } cfg_reg_e;

endpackage

### design/msp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP deframer channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface msp_rx_if;
  logic                       valid;
  logic                       ready;
  logic [msp_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msp_res_if;
  logic                       valid;
  logic                       ready;
  logic [msp_pkg::KindW-1:0]  kind;
  logic [msp_pkg::ByteW-1:0]  command;
  logic [msp_pkg::ByteW-1:0]  data;
  logic [msp_pkg::ByteW-1:0]  position;
  logic [msp_pkg::ByteW-1:0]  frame_length;
  logic                       last;

  modport source (output valid, output kind, output command, output data,
                  output position, output frame_length, output last,
                  input ready);
  modport sink   (input valid, input kind, input command, input data,
                  input position, input frame_length, input last,
                  output ready);
endinterface

interface msp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [msp_pkg::CfgIdxW-1:0]  index;
  logic [msp_pkg::ByteW-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### design/msp_v1_response_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response deframer
// Parses '$','M','>' framed responses and emits payload and frame end words.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears on out_o in the cycle after its byte is taken.
// Throughput: one byte per cycle while out_o is not stalled; the output register
// lets the next byte in while the previous result is being taken.
// Reset: rst_ni clears the parser to header hunt, filtering off, no result.
// ----------------------------------------------------------------------------
module msp_v1_response_deframer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  msp_rx_if.sink          in_i,
  msp_res_if.source       out_o,
  msp_cfg_if.sink         cfg_i
);

  logic                      filt_en_q;
  logic [msp_pkg::ByteW-1:0] filt_cmd_q;

  msp_pkg::phase_e           phase_q, phase_d;
  logic [msp_pkg::ByteW-1:0] len_q, len_d;
  logic [msp_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic [msp_pkg::ByteW-1:0] cnt_q, cnt_d;
  logic [msp_pkg::ByteW-1:0] xor_q, xor_d;
  logic                      wanted_q, wanted_d;

  logic                      out_valid_q, out_valid_d;
  msp_pkg::kind_e            kind_q, kind_d;
  logic [msp_pkg::ByteW-1:0] ocmd_q, ocmd_d;
  logic [msp_pkg::ByteW-1:0] data_q, data_d;
  logic [msp_pkg::ByteW-1:0] pos_q, pos_d;
  logic [msp_pkg::ByteW-1:0] flen_q, flen_d;
  logic                      last_q, last_d;

  logic                      in_fire;
  logic                      res_valid;
  logic [msp_pkg::ByteW-1:0] b;
  msp_pkg::phase_e           resync;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign b           = in_i.rx_byte;
  assign resync      = (b == msp_pkg::SyncDollar) ? msp_pkg::PH_EM : msp_pkg::PH_HUNT;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en_q  <= 1'b0;
      filt_cmd_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        msp_pkg::REG_FILTER_ENABLE:  filt_en_q  <= cfg_i.wdata[0];
        msp_pkg::REG_FILTER_COMMAND: filt_cmd_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    xor_d     = xor_q;
    wanted_d  = wanted_q;
    res_valid = 1'b0;
    kind_d    = msp_pkg::KIND_PAYLOAD;
    data_d    = b;
    pos_d     = '0;
    last_d    = 1'b0;
    unique case (phase_q)
      msp_pkg::PH_EM: begin
        phase_d = (b == msp_pkg::SyncEm) ? msp_pkg::PH_GT : resync;
      end
      msp_pkg::PH_GT: begin
        phase_d = (b == msp_pkg::SyncGt) ? msp_pkg::PH_LEN : resync;
      end
      msp_pkg::PH_LEN: begin
        len_d   = b;
        xor_d   = b;
        cnt_d   = '0;
        phase_d = msp_pkg::PH_CMD;
      end
      msp_pkg::PH_CMD: begin
        cmd_d    = b;
        xor_d    = xor_q ^ b;
        wanted_d = !filt_en_q || (b == filt_cmd_q);
        phase_d  = (len_q == '0) ? msp_pkg::PH_CHECK : msp_pkg::PH_DATA;
      end
      msp_pkg::PH_DATA: begin
        res_valid = wanted_q;
        pos_d     = cnt_q;
        xor_d     = xor_q ^ b;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_d == len_q) begin
          phase_d = msp_pkg::PH_CHECK;
        end
      end
      msp_pkg::PH_CHECK: begin
        res_valid = wanted_q;
        kind_d    = (b == xor_q) ? msp_pkg::KIND_SUM_OK : msp_pkg::KIND_SUM_BAD;
        last_d    = 1'b1;
        phase_d   = msp_pkg::PH_HUNT;
      end
      default: begin
        // hunting, and any unused phase code
        phase_d = resync;
      end
    endcase
    ocmd_d = cmd_q;
    flen_d = len_q;
  end

  always_comb begin
    if (in_fire) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= msp_pkg::PH_HUNT;
      len_q       <= '0;
      cmd_q       <= '0;
      cnt_q       <= '0;
      xor_q       <= '0;
      wanted_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q  <= phase_d;
        len_q    <= len_d;
        cmd_q    <= cmd_d;
        cnt_q    <= cnt_d;
        xor_q    <= xor_d;
        wanted_q <= wanted_d;
      end
    end
  end

  // Result word: load only when a new one is produced
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q <= kind_d;
      ocmd_q <= ocmd_d;
      data_q <= data_d;
      pos_q  <= pos_d;
      flen_q <= flen_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.command      = ocmd_q;
  assign out_o.data         = data_q;
  assign out_o.position     = pos_q;
  assign out_o.frame_length = flen_q;
  assign out_o.last         = last_q;

endmodule

### design/msp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP deframer port checker
// Watches the input and result channels of the deframer top level.
// ----------------------------------------------------------------------------
module msp_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [msp_pkg::KindW-1:0]  kind_i,
  input  logic [msp_pkg::ByteW-1:0]  data_i,
  input  logic [msp_pkg::ByteW-1:0]  position_i,
  input  logic                       last_i
);

  // A stalled result word must hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(data_i)
      && $stable(position_i) && $stable(last_i))
    else $error("result word changed while stalled");

  // last marks exactly the frame end words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((kind_i == msp_pkg::KIND_PAYLOAD) && !last_i)
      || ((kind_i == msp_pkg::KIND_SUM_OK || kind_i == msp_pkg::KIND_SUM_BAD) && last_i))
    else $error("kind and last disagree");

  // frame end words carry position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> position_i == '0)
    else $error("frame end with non-zero position");

  // a byte must be taken whenever the output side is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

endmodule

bind msp_v1_response_deframer_top msp_checker u_msp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .data_i      (out_o.data),
  .position_i  (out_o.position),
  .last_i      (out_o.last)
);

### sim/msp_v1_response_deframer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP v1 response deframer testbench
// Drives received bytes into the deframer and checks every payload and frame
// end word against the scripted values or an in-bench model of the parser.
// A short scripted opening is followed by random frames, header noise and
// broken headers under several filter settings, with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module msp_v1_response_deframer_top_tb;

  localparam int unsigned StuckLimit  = 1000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned PhaseBytes  = 300;

  typedef struct packed {
    msp_pkg::kind_e            kind;
    logic [msp_pkg::ByteW-1:0] command;
    logic [msp_pkg::ByteW-1:0] data;
    logic [msp_pkg::ByteW-1:0] position;
    logic [msp_pkg::ByteW-1:0] frame_length;
    logic                      last;
  } deframe_res_t;

  typedef struct packed {
    logic [msp_pkg::ByteW-1:0] rx;
    logic                      typed;
    deframe_res_t              res;
  } script_row_t;

  localparam deframe_res_t NoRes = '{msp_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};

  // Filtering off: a two-byte frame with extreme payload values, then a broken
  // header restarted by a second dollar sign, an empty frame and a bad sum.
  localparam script_row_t OpenScript [15] = '{
    '{msp_pkg::SyncDollar, 1'b0, NoRes},
    '{msp_pkg::SyncEm,     1'b0, NoRes},
    '{msp_pkg::SyncGt,     1'b0, NoRes},
    '{8'h02,               1'b0, NoRes},
    '{8'h6C,               1'b0, NoRes},
    '{8'h00, 1'b1, '{msp_pkg::KIND_PAYLOAD, 8'h6C, 8'h00, 8'h00, 8'h02, 1'b0}},
    '{8'hFF, 1'b1, '{msp_pkg::KIND_PAYLOAD, 8'h6C, 8'hFF, 8'h01, 8'h02, 1'b0}},
    '{8'h91, 1'b1, '{msp_pkg::KIND_SUM_OK,  8'h6C, 8'h91, 8'h00, 8'h02, 1'b1}},
    '{msp_pkg::SyncDollar, 1'b0, NoRes},
    '{msp_pkg::SyncDollar, 1'b0, NoRes},
    '{msp_pkg::SyncEm,     1'b0, NoRes},
    '{msp_pkg::SyncGt,     1'b0, NoRes},
    '{8'h00,               1'b0, NoRes},
    '{8'hFF,               1'b0, NoRes},
    '{8'h00, 1'b1, '{msp_pkg::KIND_SUM_BAD, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1}}
  };

  // Filtering on command 0x00: the first frame must vanish, the second pass.
  localparam script_row_t FilterScript [12] = '{
    '{msp_pkg::SyncDollar, 1'b0, NoRes},
    '{msp_pkg::SyncEm,     1'b0, NoRes},
    '{msp_pkg::SyncGt,     1'b0, NoRes},
    '{8'h00,               1'b0, NoRes},
    '{8'h6C,               1'b0, NoRes},
    '{8'h6C,               1'b0, NoRes},
    '{msp_pkg::SyncDollar, 1'b0, NoRes},
    '{msp_pkg::SyncEm,     1'b0, NoRes},
    '{msp_pkg::SyncGt,     1'b0, NoRes},
    '{8'h00,               1'b0, NoRes},
    '{8'h00,               1'b0, NoRes},
    '{8'h00, 1'b1, '{msp_pkg::KIND_SUM_OK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  msp_rx_if  rx_bus ();
  msp_res_if res_bus ();
  msp_cfg_if cfg_bus ();

  msp_v1_response_deframer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rx_bus),
    .out_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Parser model state
  msp_pkg::phase_e           cur_phase     = msp_pkg::PH_HUNT;
  logic [msp_pkg::ByteW-1:0] decl_len      = '0;
  logic [msp_pkg::ByteW-1:0] frame_cmd     = '0;
  logic [msp_pkg::ByteW-1:0] payload_idx   = '0;
  logic [msp_pkg::ByteW-1:0] sum_acc       = '0;
  logic                      frame_wanted  = 1'b1;
  logic                      filt_en       = 1'b0;
  logic [msp_pkg::ByteW-1:0] filt_cmd      = '0;

  deframe_res_t due_results [$];

  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned sum_ok_seen     = 0;
  int unsigned sum_bad_seen    = 0;
  int unsigned bytes_taken     = 0;
  int unsigned frames_sent     = 0;
  int unsigned settings_used   = 1;
  int unsigned phase_bytes     = 0;
  int unsigned stuck_cycles    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic msp_pkg::phase_e after_break(input logic [msp_pkg::ByteW-1:0] b);
    return (b == msp_pkg::SyncDollar) ? msp_pkg::PH_EM : msp_pkg::PH_HUNT;
  endfunction

  // Append a word to the list of words owed by the block.
  function automatic void owe_word(input deframe_res_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  // Advance the parser model by one byte; returns 1 when a word is due.
  function automatic bit deframe_step(input logic [msp_pkg::ByteW-1:0] b,
                                      output deframe_res_t r);
    bit produced;
    produced = 1'b0;
    r = NoRes;
    case (cur_phase)
      msp_pkg::PH_EM: cur_phase = (b == msp_pkg::SyncEm) ? msp_pkg::PH_GT : after_break(b);
      msp_pkg::PH_GT: cur_phase = (b == msp_pkg::SyncGt) ? msp_pkg::PH_LEN : after_break(b);
      msp_pkg::PH_LEN: begin
        decl_len    = b;
        sum_acc     = b;
        payload_idx = '0;
        cur_phase   = msp_pkg::PH_CMD;
      end
      msp_pkg::PH_CMD: begin
        frame_cmd    = b;
        sum_acc      = sum_acc ^ b;
        frame_wanted = !filt_en || (b == filt_cmd);
        cur_phase    = (decl_len == 0) ? msp_pkg::PH_CHECK : msp_pkg::PH_DATA;
      end
      msp_pkg::PH_DATA: begin
        if (frame_wanted) begin
          r = '{msp_pkg::KIND_PAYLOAD, frame_cmd, b, payload_idx, decl_len, 1'b0};
          produced = 1'b1;
        end
        sum_acc     = sum_acc ^ b;
        payload_idx = payload_idx + 1'b1;
        if (payload_idx == decl_len) cur_phase = msp_pkg::PH_CHECK;
      end
      msp_pkg::PH_CHECK: begin
        if (frame_wanted) begin
          r = '{msp_pkg::KIND_SUM_BAD, frame_cmd, b, 8'h00, decl_len, 1'b1};
          if (b == sum_acc) r.kind = msp_pkg::KIND_SUM_OK;
          produced = 1'b1;
        end
        cur_phase = msp_pkg::PH_HUNT;
      end
      default: cur_phase = after_break(b);
    endcase
    return produced;
  endfunction

  // Offer one byte, idling first at random, and log what it should cause.
  task automatic offer_byte(input logic [msp_pkg::ByteW-1:0] b, input bit typed = 1'b0,
                            input deframe_res_t want = NoRes);
    int unsigned gap;
    deframe_res_t r;
    bit produced;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      rx_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (rx_bus.ready !== 1'b1);
    bytes_taken++;
    produced = deframe_step(b, r);
    if (typed) owe_word(want);
    else if (produced) owe_word(r);
  endtask

  // Drop valid and hold until every owed word is out and the pipe is quiet.
  task automatic settle();
    @(negedge clk_i);
    rx_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input msp_pkg::cfg_reg_e idx,
                           input logic [msp_pkg::ByteW-1:0] v);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= v;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    case (idx)
      msp_pkg::REG_FILTER_ENABLE:  filt_en  = v[0];
      msp_pkg::REG_FILTER_COMMAND: filt_cmd = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // A frame with random content and now and then a bad sum; a negative length picks one.
  task automatic send_frame(input int len_pick, input bit force_hit);
    int unsigned n, r;
    logic [msp_pkg::ByteW-1:0] cmd, sum, pl;
    if (len_pick >= 0) begin
      n = len_pick;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 85)      n = $urandom_range(0, 8);
      else if (r < 97) n = $urandom_range(9, 40);
      else             n = $urandom_range(41, 255);
    end
    if (force_hit || (filt_en && $urandom_range(0, 2) != 0)) cmd = filt_cmd;
    else cmd = 8'($urandom_range(0, 255));
    offer_byte(msp_pkg::SyncDollar);
    offer_byte(msp_pkg::SyncEm);
    offer_byte(msp_pkg::SyncGt);
    offer_byte(n[msp_pkg::ByteW-1:0]);
    offer_byte(cmd);
    sum = n[msp_pkg::ByteW-1:0] ^ cmd;
    repeat (n) begin
      pl = 8'($urandom_range(0, 255));
      sum = sum ^ pl;
      offer_byte(pl);
    end
    if ($urandom_range(0, 6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    offer_byte(sum);
    frames_sent++;
    phase_bytes += n + 6;
  endtask

  // Line noise: stray bytes, or a header cut short after one or two bytes.
  task automatic send_noise();
    int unsigned depth;
    logic [msp_pkg::ByteW-1:0] cont, x;
    depth = $urandom_range(0, 2);
    if (depth == 0) begin
      repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(0, 255)));
    end else begin
      offer_byte(msp_pkg::SyncDollar);
      if (depth == 2) offer_byte(msp_pkg::SyncEm);
      cont = (depth == 1) ? msp_pkg::SyncEm : msp_pkg::SyncGt;
      if ($urandom_range(0, 1) == 0) begin
        x = msp_pkg::SyncDollar;
      end else begin
        do x = 8'($urandom_range(0, 255)); while (x == cont);
      end
      offer_byte(x);
    end
  endtask

  task automatic run_random();
    phase_bytes = 0;
    while (phase_bytes < PhaseBytes) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_frame(-1, 1'b0);
    end
    settle();
  endtask

  task automatic report_mismatch(input string what, input logic [msp_pkg::ByteW-1:0] got,
                                 input logic [msp_pkg::ByteW-1:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("%0t: %s mismatch on word %0d: got %h, want %h",
               $realtime, what, results_checked, got, want);
  endtask

  always @(posedge clk_i) begin : result_check
    deframe_res_t want;
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word", res_bus.data, 8'h00);
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (want.kind == msp_pkg::KIND_SUM_OK)  sum_ok_seen++;
        if (want.kind == msp_pkg::KIND_SUM_BAD) sum_bad_seen++;
        if (res_bus.kind !== want.kind)
          report_mismatch("kind", 8'(res_bus.kind), 8'(want.kind));
        if (res_bus.command !== want.command)
          report_mismatch("command", res_bus.command, want.command);
        if (res_bus.data !== want.data)
          report_mismatch("data", res_bus.data, want.data);
        if (res_bus.position !== want.position)
          report_mismatch("position", res_bus.position, want.position);
        if (res_bus.frame_length !== want.frame_length)
          report_mismatch("frame_length", res_bus.frame_length, want.frame_length);
        if (res_bus.last !== want.last)
          report_mismatch("last", 8'(res_bus.last), 8'(want.last));
      end
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin : result_drain
    int unsigned hold_left, stall_left;
    hold_left  = 0;
    stall_left = 0;
    res_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold_left     = HoldCycles;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d words still owed",
                 $realtime, StuckLimit, due_results.size());
        $display("msp_v1_response_deframer_top_tb NOT OK");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = msp_pkg::REG_FILTER_ENABLE;
    cfg_bus.wdata  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (OpenScript[i])
      offer_byte(OpenScript[i].rx, OpenScript[i].typed, OpenScript[i].res);
    settle();
    write_reg(msp_pkg::REG_FILTER_ENABLE, 8'h01);
    write_reg(msp_pkg::REG_FILTER_COMMAND, 8'h00);
    settings_used++;
    foreach (FilterScript[i])
      offer_byte(FilterScript[i].rx, FilterScript[i].typed, FilterScript[i].res);
    settle();

    // Stall the output while a full-length frame is offered behind it.
    long_hold_req = 1'b1;
    send_frame(255, 1'b1);
    run_random();

    write_reg(msp_pkg::REG_FILTER_COMMAND, 8'hFF);
    settings_used++;
    run_random();

    write_reg(msp_pkg::REG_FILTER_COMMAND, 8'($urandom_range(0, 255)));
    settings_used++;
    run_random();

    write_reg(msp_pkg::REG_FILTER_ENABLE, 8'h00);
    write_reg(msp_pkg::REG_FILTER_COMMAND, 8'($urandom_range(0, 255)));
    settings_used++;
    run_random();

    // Back to back on both sides for the closing stretch.
    quiet = 1'b1;
    run_random();

    $display("Sent %0d bytes in %0d frames plus noise across %0d filter settings.",
             bytes_taken, frames_sent, settings_used);
    $display("Checked %0d words: %0d frames closed with good sum, %0d with bad sum.",
             results_checked, sum_ok_seen, sum_bad_seen);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("msp_v1_response_deframer_top_tb OK");
    end else begin
      $display("msp_v1_response_deframer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
design/msp_pkg.sv
design/msp_if.sv
design/msp_v1_response_deframer_top.sv
design/msp_checker.sv
sim/msp_v1_response_deframer_top_tb.sv
